[hw/rtl/bdq_pkg.sv]
`timescale 1ns / 1ps

package bdq_pkg;

  // Request codes
  localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
  localparam logic [3:0] MODE_POP_BACK   = 4'd3;
  localparam logic [3:0] MODE_PEEK_FRONT = 4'd4;
  localparam logic [3:0] MODE_PEEK_BACK  = 4'd5;
  localparam logic [3:0] MODE_PEEK_INDEX = 4'd6;
  localparam logic [3:0] MODE_REMOVE     = 4'd7;
  localparam logic [3:0] MODE_CLEAR      = 4'd8;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_MISS  = 2'd3;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [3:0]         mode;
    logic [VALUE_W-1:0] value;
    logic [3:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic [1:0]         status;
  } out_item_t;

endpackage

[hw/rtl/bdq_mem.sv]
`timescale 1ns / 1ps

module bdq_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bdq_slot.sv]
`timescale 1ns / 1ps

module bdq_slot #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] front,
  input  logic [$clog2(DEPTH)-1:0] pos,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int PW = $clog2(DEPTH);

  logic [PW:0] sum;
  logic [PW:0] wrapped;

  // Wrap front plus position around the ring
  always_comb begin
    sum     = {1'b0, front} + {1'b0, pos};
    wrapped = sum - (PW+1)'(DEPTH);
    slot    = (sum >= (PW+1)'(DEPTH)) ? wrapped[PW-1:0] : sum[PW-1:0];
  end

endmodule

[hw/rtl/bdq_seq.sv]
`timescale 1ns / 1ps

module bdq_seq
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  output out_item_t                out_item,
  output logic                     mem_rd_en,
  output logic [$clog2(DEPTH)-1:0] mem_rd_addr,
  input  logic [DATA_WIDTH-1:0]    mem_rd_data,
  output logic                     mem_wr_en,
  output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
  output logic [DATA_WIDTH-1:0]    mem_wr_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_t;

  state_t                state_r, state_nxt;
  logic [PW-1:0]         front_r, front_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic [OW-1:0]         pos_r, pos_nxt;
  logic [PW-1:0]         rd_slot_r, rd_slot_nxt;
  logic [PW-1:0]         hole_r, hole_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic [PW-1:0]         slot_pos;
  logic [PW-1:0]         slot;
  logic [PW-1:0]         front_dec;
  logic [PW-1:0]         front_inc;
  logic [XW-1:0]         value_ext;
  logic [XW-1:0]         rd_ext;
  logic [DATA_WIDTH-1:0] word_in;
  logic [OW:0]           pos_p1;
  logic [OW:0]           pos_p2;
  logic [OW:0]           occ_ext;
  logic                  accept;
  logic                  immediate;

  // Shared ring-position unit
  bdq_slot #(
    .DEPTH (DEPTH)
  ) u_slot (
    .front (front_r),
    .pos   (slot_pos),
    .slot  (slot)
  );

  // Fit words between the port width and the stored width
  always_comb begin
    value_ext = XW'(in_item.value);
    word_in   = value_ext[DATA_WIDTH-1:0];
    rd_ext    = XW'(mem_rd_data);
  end

  always_comb begin
    front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - 1'b1;
    front_inc = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
    pos_p1    = {1'b0, pos_r} + 1'b1;
    pos_p2    = {1'b0, pos_r} + 2'd2;
    occ_ext   = {1'b0, occ_r};
    accept    = start && (state_r == ST_IDLE);
  end

  // Pick the position that the ring unit resolves this cycle
  always_comb begin
    slot_pos = '0;
    case (state_r)
      ST_IDLE: begin
        case (in_item.mode)
          MODE_PUSH_BACK:                slot_pos = PW'(occ_r);
          MODE_POP_BACK, MODE_PEEK_BACK: slot_pos = PW'(occ_r - 1'b1);
          MODE_PEEK_INDEX:               slot_pos = PW'(in_item.index);
          default:                       slot_pos = '0;
        endcase
      end
      ST_SCAN_RD:  slot_pos = PW'(pos_r);
      ST_SHIFT_RD: slot_pos = PW'(pos_p1);
      default:     slot_pos = '0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    occ_nxt       = occ_r;
    pos_nxt       = pos_r;
    rd_slot_nxt   = rd_slot_r;
    hole_nxt      = hole_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = slot;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = slot;
    mem_wr_data   = word_in;
    immediate     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          word_nxt        = word_in;
          pos_nxt         = '0;
          out_nxt.data    = '0;
          out_nxt.hit     = 1'b0;
          out_nxt.count   = COUNT_W'(occ_r);
          out_nxt.status  = STATUS_OK;
          out_valid_nxt   = 1'b1;
          immediate       = 1'b1;
          case (in_item.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (occ_r == OW'(DEPTH)) begin
                out_nxt.status = STATUS_FULL;
              end else begin
                mem_wr_en = 1'b1;
                if (in_item.mode == MODE_PUSH_FRONT) begin
                  front_nxt   = front_dec;
                  mem_wr_addr = front_dec;
                end
                occ_nxt       = occ_r + 1'b1;
                out_nxt.hit   = 1'b1;
                out_nxt.count = COUNT_W'(occ_r + 1'b1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
              if (occ_r == '0) begin
                out_nxt.status = STATUS_EMPTY;
              end else begin
                mem_rd_en     = 1'b1;
                state_nxt     = ST_READ;
                out_valid_nxt = 1'b0;
                immediate     = 1'b0;
                if (in_item.mode == MODE_POP_FRONT) begin
                  front_nxt = front_inc;
                end
                if (in_item.mode == MODE_POP_FRONT || in_item.mode == MODE_POP_BACK) begin
                  occ_nxt = occ_r - 1'b1;
                end
              end
            end
            MODE_PEEK_INDEX: begin
              if (32'(in_item.index) >= 32'(occ_r)) begin
                out_nxt.status = STATUS_MISS;
              end else begin
                mem_rd_en     = 1'b1;
                state_nxt     = ST_READ;
                out_valid_nxt = 1'b0;
                immediate     = 1'b0;
              end
            end
            MODE_REMOVE: begin
              if (occ_r == '0) begin
                out_nxt.status = STATUS_MISS;
              end else begin
                state_nxt     = ST_SCAN_RD;
                out_valid_nxt = 1'b0;
                immediate     = 1'b0;
              end
            end
            MODE_CLEAR: begin
              occ_nxt       = '0;
              front_nxt     = '0;
              out_nxt.count = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Return the word read on the accept cycle
      ST_READ: begin
        out_nxt.data   = rd_ext[VALUE_W-1:0];
        out_nxt.hit    = 1'b1;
        out_nxt.count  = COUNT_W'(occ_r);
        out_nxt.status = STATUS_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end

      // Fetch the next candidate
      ST_SCAN_RD: begin
        mem_rd_en   = 1'b1;
        rd_slot_nxt = slot;
        state_nxt   = ST_SCAN_CMP;
      end

      // Compare the candidate against the wanted word
      ST_SCAN_CMP: begin
        if (mem_rd_data == word_r) begin
          hole_nxt = rd_slot_r;
          if (pos_p1 < occ_ext) begin
            state_nxt = ST_SHIFT_RD;
          end else begin
            occ_nxt        = occ_r - 1'b1;
            out_nxt.data   = '0;
            out_nxt.hit    = 1'b1;
            out_nxt.count  = COUNT_W'(occ_r - 1'b1);
            out_nxt.status = STATUS_OK;
            out_valid_nxt  = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (pos_p1 < occ_ext) begin
          pos_nxt   = OW'(pos_p1);
          state_nxt = ST_SCAN_RD;
        end else begin
          out_nxt.data   = '0;
          out_nxt.hit    = 1'b0;
          out_nxt.count  = COUNT_W'(occ_r);
          out_nxt.status = STATUS_MISS;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      // Fetch the entry behind the hole
      ST_SHIFT_RD: begin
        mem_rd_en   = 1'b1;
        rd_slot_nxt = slot;
        state_nxt   = ST_SHIFT_WR;
      end

      // Move it into the hole and advance
      ST_SHIFT_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = hole_r;
        mem_wr_data = mem_rd_data;
        hole_nxt    = rd_slot_r;
        pos_nxt     = OW'(pos_p1);
        if (pos_p2 < occ_ext) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          occ_nxt        = occ_r - 1'b1;
          out_nxt.data   = '0;
          out_nxt.hit    = 1'b1;
          out_nxt.count  = COUNT_W'(occ_r - 1'b1);
          out_nxt.status = STATUS_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    rd_slot_r <= rd_slot_nxt;
    hole_r    <= hole_nxt;
    word_r    <= word_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Occupancy stays within the ring
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("occupancy exceeds depth");

  // A transaction that needs no memory read answers on the next cycle
  a_immediate: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && immediate) |=> (out_valid_r && !busy))
    else $error("immediate transaction gave no result");

  // The read state leads straight back to idle with a valid result
  a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("read result late");

  // Busy drops only together with a result
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid_r)
    else $error("busy dropped without a result");

endmodule

[hw/rtl/bounded_deque_with_remove_top.sv]
`timescale 1ns / 1ps

// Bounded double-ended queue with remove-by-value.
// Requests enter on in_item when start is high and busy is low; each request
// gives exactly one result on out_item, shown for one cycle with out_valid.
// The receiver cannot stall: the result must be taken in that cycle.
// How each kind of request is answered:
//   push, clear, refused or unused requests: result in the next cycle, busy stays low.
//   pop and peek: one registered read of the entry memory, then the result.
//   remove: scans each entry in turn (SCAN_RD, SCAN_CMP); on a match,
//   moves each later entry into the gap (SHIFT_RD, SHIFT_WR).
// While busy is high no request is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any result in
// flight; stored entries are not cleared, and none is read before rewritten.
// DEPTH sets the number of entries, DATA_WIDTH the stored word width; words
// are the low DATA_WIDTH bits of value. count carries the low five bits of
// the occupancy.
module bounded_deque_with_remove_top
  import bdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PW = $clog2(DEPTH);

  logic                  mem_rd_en;
  logic [PW-1:0]         mem_rd_addr;
  logic [DATA_WIDTH-1:0] mem_rd_data;
  logic                  mem_wr_en;
  logic [PW-1:0]         mem_wr_addr;
  logic [DATA_WIDTH-1:0] mem_wr_data;

  // Sequencer
  bdq_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  // Entry ring
  bdq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

endmodule
